// ----- rtl/core/mma_pkg.sv -----
// ============================================================================
// MIDI message assembler package
// Shared types and constants for the message assembler core.
// ============================================================================
`default_nettype none

package mma_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 5;
    localparam int LEN_W   = 6;
    localparam int MAX_RUN = 32;

    localparam logic [BYTE_W-1:0] STATUS_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] CHANNEL_MAX = 8'hEF;
    localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
    localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;
    localparam logic [BYTE_W-1:0] MIDI_RESET  = 8'hFF;

    // high nibbles of the two-byte channel messages
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;

    typedef enum logic [1:0] {
        PM_IDLE    = 2'd0,
        PM_CHANNEL = 2'd1,
        PM_SYSEX   = 2'd2
    } t_parse_mode;

    typedef enum logic [1:0] {
        SQ_RECV = 2'd0,
        SQ_READ = 2'd1,
        SQ_LOAD = 2'd2
    } t_seq_state;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
    } t_store_rd;

endpackage

`default_nettype wire

// ----- rtl/core/mma_store.sv -----
// ============================================================================
// MIDI message store
// Single-port-write, single-port-read byte memory with a registered read.
// ============================================================================
`default_nettype none

module mma_store
    import mma_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic              i_clk,
    input  wire t_store_wr         i_wr,
    input  wire t_store_rd         i_rd,
    output logic [BYTE_W-1:0]      o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    // hold read data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_rd_data <= r_mem[i_rd.addr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/midi_message_assembler_top.sv -----
// ============================================================================
// MIDI message assembler
// Assembles channel, sysex and reset messages from received MIDI bytes.
// ============================================================================
// Received bytes come in one word per accepted handshake on the rx channel.
// While idle the block waits for a status byte: 0x80-0xEF opens a channel
// message (three bytes, or two for Cx and Dx), 0xF0 opens a sysex message
// that runs up to and including 0xF7, and 0xFF is a one-byte reset message.
// Idle data bytes and other system bytes are dropped; status bytes inside a
// channel message are dropped as well (no running status). Inside sysex every
// byte is stored; bytes beyond the store (min(MSG_BUFFER_DEPTH, 32) entries)
// are dropped and the run is flagged truncated. Stored bytes are kept in a
// one-read, one-write message memory. An rx word that does not finish a
// message is taken without a stall. A word that finishes a message holds
// the rx channel while the message is replayed as a run of msg words, one
// per stored byte, status byte first; each result takes a memory read
// (SQ_READ) and then a load of the output register (SQ_LOAD), which waits
// while the msg side stalls. The output register lets a new rx word in
// while the last msg word of a run still waits to be taken.
`default_nettype none

module midi_message_assembler_top
    import mma_pkg::*;
#(
    parameter int MSG_BUFFER_DEPTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_valid,
    output logic                   o_rx_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   o_msg_valid,
    input  wire logic              i_msg_stall,
    output logic [BYTE_W-1:0]      o_msg_byte,
    output logic [POS_W-1:0]       o_byte_position,
    output logic [LEN_W-1:0]       o_msg_length,
    output logic                   o_last_byte,
    output logic                   o_truncated
);

    // store never exceeds one full run
    localparam int STORE_CAP = (MSG_BUFFER_DEPTH > MAX_RUN) ? MAX_RUN : MSG_BUFFER_DEPTH;
    localparam logic [LEN_W-1:0] CAP_CNT = LEN_W'(STORE_CAP);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_parse_mode      r_mode, n_mode;
    logic [1:0]       r_rem, n_rem;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic             r_ovf, n_ovf;

    // run replay state
    t_seq_state       r_state, n_state;
    logic [POS_W-1:0] r_k;
    logic [LEN_W-1:0] r_run_len;
    logic             r_run_trunc;

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_pos;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_last;
    logic              r_out_trunc;

    // per-word decode
    logic             rx_take;
    logic             put;
    logic             wr_en;
    logic [LEN_W-1:0] fill_base;
    logic             ovf_base;
    logic [LEN_W-1:0] fill_put;
    logic             ovf_put;
    logic             run_end;
    logic             run_trunc;
    logic [1:0]       rem_dec;

    // sequencer outputs
    logic             out_free;
    logic             rd_issue;
    logic             out_load;
    logic             k_last;

    t_store_wr         st_wr;
    t_store_rd         st_rd;
    logic [BYTE_W-1:0] st_rd_data;

    assign rx_take  = i_rx_valid && !o_rx_stall;
    assign out_free = !r_out_valid || !i_msg_stall;
    assign k_last   = (({1'b0, r_k} + LEN_W'(1)) == r_run_len);

    // ------------------------------------------------------------------
    // Byte classification and store update
    // ------------------------------------------------------------------
    always_comb begin
        n_mode    = r_mode;
        n_rem     = r_rem;
        fill_base = r_fill;
        ovf_base  = r_ovf;
        put       = 1'b0;
        run_end   = 1'b0;
        run_trunc = 1'b0;
        rem_dec   = r_rem;

        if (rx_take) begin
            case (r_mode)
                PM_CHANNEL: begin
                    // drop status bytes inside a channel message
                    if (!i_rx_byte[7]) begin
                        put     = 1'b1;
                        rem_dec = (r_rem != 2'd0) ? r_rem - 2'd1 : r_rem;
                        n_rem   = rem_dec;
                        run_end = (rem_dec == 2'd0);
                    end
                end
                PM_SYSEX: begin
                    put     = 1'b1;
                    run_end = (i_rx_byte == SYSEX_END);
                end
                default: begin
                    n_mode = PM_IDLE;
                    if (i_rx_byte[7]) begin
                        fill_base = '0;
                        ovf_base  = 1'b0;
                        if (i_rx_byte inside {[STATUS_MIN:CHANNEL_MAX]}) begin
                            put    = 1'b1;
                            n_mode = PM_CHANNEL;
                            if (i_rx_byte[7:4] inside {NIB_PROGRAM, NIB_PRESSURE}) begin
                                n_rem = 2'd1;
                            end else begin
                                n_rem = 2'd2;
                            end
                        end else if (i_rx_byte == SYSEX_START) begin
                            put    = 1'b1;
                            n_mode = PM_SYSEX;
                        end else if (i_rx_byte == MIDI_RESET) begin
                            put     = 1'b1;
                            run_end = 1'b1;
                        end
                    end
                end
            endcase
        end

        // store the byte while there is room, else flag the overflow
        wr_en    = put && (fill_base < CAP_CNT);
        fill_put = wr_en ? fill_base + LEN_W'(1) : fill_base;
        ovf_put  = (put && !wr_en) ? 1'b1 : ovf_base;

        if (r_mode == PM_SYSEX) begin
            run_trunc = ovf_put;
        end

        n_fill = fill_put;
        n_ovf  = ovf_put;
        if (run_end) begin
            n_fill = '0;
            n_ovf  = 1'b0;
            n_rem  = 2'd0;
            n_mode = PM_IDLE;
        end
    end

    always_comb begin
        st_wr.en   = wr_en;
        st_wr.addr = fill_base[POS_W-1:0];
        st_wr.data = i_rx_byte;
        st_rd.en   = rd_issue;
        st_rd.addr = r_k;
    end

    mma_store #(
        .DEPTH (STORE_CAP)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (st_wr),
        .i_rd      (st_rd),
        .o_rd_data (st_rd_data)
    );

    // ------------------------------------------------------------------
    // Run replay sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_RECV: begin
                if (run_end) begin
                    n_state = SQ_READ;
                end
            end
            SQ_READ: begin
                n_state = SQ_LOAD;
            end
            SQ_LOAD: begin
                if (out_free) begin
                    n_state = k_last ? SQ_RECV : SQ_READ;
                end
            end
            default: begin
                n_state = SQ_RECV;
            end
        endcase
    end

    always_comb begin
        o_rx_stall = 1'b1;
        rd_issue   = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            SQ_RECV: begin
                o_rx_stall = 1'b0;
            end
            SQ_READ: begin
                rd_issue = 1'b1;
            end
            SQ_LOAD: begin
                out_load = out_free;
            end
            default: begin
                o_rx_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= PM_IDLE;
            r_rem       <= 2'd0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_state     <= SQ_RECV;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_rem   <= n_rem;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_state <= n_state;

            if (run_end) begin
                r_k <= '0;
            end else if (out_load) begin
                r_k <= r_k + POS_W'(1);
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_msg_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the run header when a message closes
    always_ff @(posedge i_clk) begin
        if (run_end) begin
            r_run_len   <= fill_put;
            r_run_trunc <= run_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte  <= st_rd_data;
            r_out_pos   <= r_k;
            r_out_len   <= r_run_len;
            r_out_last  <= k_last;
            r_out_trunc <= r_run_trunc;
        end
    end

    assign o_msg_valid     = r_out_valid;
    assign o_msg_byte      = r_out_byte;
    assign o_byte_position = r_out_pos;
    assign o_msg_length    = r_out_len;
    assign o_last_byte     = r_out_last;
    assign o_truncated     = r_out_trunc;

endmodule

`default_nettype wire

// ----- rtl/core/mma_checker.sv -----
// ============================================================================
// MIDI message assembler checker
// Port-level properties of the message runs, bound to the top level.
// ============================================================================
`default_nettype none

module mma_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_msg_valid,
    input wire logic       i_msg_stall,
    input wire logic [7:0] o_msg_byte,
    input wire logic [4:0] o_byte_position,
    input wire logic [5:0] o_msg_length,
    input wire logic       o_last_byte,
    input wire logic       o_truncated
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_msg_valid)
        else $error("msg word valid after reset");

    // every position lies inside the message
    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid |-> ({1'b0, o_byte_position} < o_msg_length))
        else $error("byte position beyond message length");

    // the last word sits at the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg_valid && o_last_byte) |-> (({1'b0, o_byte_position} + 6'd1) == o_msg_length))
        else $error("last byte not at final position");

    // every run opens with a status byte
    a_first_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg_valid && (o_byte_position == 5'd0)) |-> o_msg_byte[7])
        else $error("run does not open with a status byte");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg_valid && i_msg_stall) |=> (o_msg_valid && $stable(o_msg_byte)
            && $stable(o_byte_position) && $stable(o_truncated)))
        else $error("stalled msg word changed");

endmodule

bind midi_message_assembler_top mma_checker u_mma_checker (.*);

`default_nettype wire
